// ===== rtl/integer_to_ascii_formatter_macros.svh =====
// assertion macros for the integer to ascii formatter
// used by the top level only, no other dependencies
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// same-cycle implication
`define ITOA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itoa check failed");

// next-cycle implication
`define ITOA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itoa check failed");

`endif

// ===== rtl/itoa_pkg.sv =====
// shared constants, types and helpers for the integer to ascii formatter
// no dependencies
`default_nettype none

package itoa_pkg;

   // conversion kinds
   localparam logic [1:0] KIND_SDEC  = 2'd0;
   localparam logic [1:0] KIND_UDEC  = 2'd1;
   localparam logic [1:0] KIND_LHEX  = 2'd2;
   localparam logic [1:0] KIND_UHEX  = 2'd3;

   localparam int MAX_FIELD_WIDTH_DEF = 63;
   localparam int DIGIT_DEPTH         = 11;
   localparam logic [3:0] DIGIT_LIMIT = 4'd10;

   // ascii codes
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LOWER = 8'h61;
   localparam logic [7:0] CH_UPPER = 8'h41;

   // ceil(2^35 / 10), exact quotient for any 32-bit dividend
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

   typedef logic [DIGIT_DEPTH-1:0][3:0] digits_type;

   // formatting attributes handed to the character selector
   typedef struct packed {
      logic       neg;
      logic       left;
      logic       zpad;
      logic       upper;
      logic [3:0] nd;
      logic [5:0] pad;
   } fmt_type;

   function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [7:0] base;
      base = upper ? CH_UPPER : CH_LOWER;
      if (nib < 4'd10) begin
         digit_char = CH_ZERO + {4'b0, nib};
      end else begin
         digit_char = base + {4'b0, nib - 4'd10};
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/itoa_digit_unit.sv =====
// shared divide-by-base unit: one digit per pass, reciprocal multiply for base ten
// depends on itoa_pkg
`default_nettype none

module itoa_digit_unit (
   input  wire logic        clock,
   input  wire logic        mul_en,
   input  wire logic        hex,
   input  wire logic [31:0] mag,
   output logic      [31:0] quot,
   output logic      [3:0]  rem
);

   logic [63:0] product_ff;
   logic [63:0] product_in;
   logic [31:0] dec_q;
   logic [31:0] dec_q10;
   logic [31:0] dec_r;

   // multiply by the reciprocal of ten, registered
   assign product_in = {32'b0, mag} * {32'b0, itoa_pkg::RECIP_TEN};

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   // quotient and remainder, base ten from the product, base sixteen by shift
   assign dec_q   = {3'b0, product_ff[63:35]};
   assign dec_q10 = (dec_q << 3) + (dec_q << 1);
   assign dec_r   = mag - dec_q10;

   always_comb begin
      if (hex) begin
         quot = {4'b0, mag[31:4]};
         rem  = mag[3:0];
      end else begin
         quot = dec_q;
         rem  = dec_r[3:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/itoa_char_select.sv =====
// picks the character at one output position: padding, sign or digit
// depends on itoa_pkg
`default_nettype none

module itoa_char_select (
   input  wire logic [5:0]              pos,
   input  wire itoa_pkg::fmt_type       fmt,
   input  wire itoa_pkg::digits_type    digits,
   output logic      [7:0]              out_char
);

   logic [5:0] sgn;
   logic [5:0] nd6;
   logic [5:0] j;
   logic [5:0] k;
   logic [5:0] d;
   logic [3:0] idx;
   logic [7:0] dchar;

   assign sgn = {5'b0, fmt.neg};
   assign nd6 = {2'b0, fmt.nd};
   assign j   = pos - fmt.pad;
   assign k   = pos - sgn;

   // digit index from the most significant end
   always_comb begin
      if (fmt.left) begin
         d = k;
      end else if (fmt.zpad) begin
         d = k - fmt.pad;
      end else begin
         d = j - sgn;
      end
   end

   assign idx   = fmt.nd - 4'd1 - d[3:0];
   assign dchar = itoa_pkg::digit_char(digits[idx], fmt.upper);

   // layout per justification mode
   always_comb begin
      if (fmt.left) begin
         if (fmt.neg && pos == 6'd0) begin
            out_char = itoa_pkg::CH_MINUS;
         end else if (k < nd6) begin
            out_char = dchar;
         end else begin
            out_char = itoa_pkg::CH_SPACE;
         end
      end else if (fmt.zpad) begin
         if (fmt.neg && pos == 6'd0) begin
            out_char = itoa_pkg::CH_MINUS;
         end else if (k < fmt.pad) begin
            out_char = itoa_pkg::CH_ZERO;
         end else begin
            out_char = dchar;
         end
      end else begin
         if (pos < fmt.pad) begin
            out_char = itoa_pkg::CH_SPACE;
         end else if (fmt.neg && j == 6'd0) begin
            out_char = itoa_pkg::CH_MINUS;
         end else begin
            out_char = dchar;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
// top level of the integer to ascii formatter: sequencer, digit store, output register
// depends on itoa_pkg, itoa_digit_unit, itoa_char_select and the macros header
//
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | type, value, field width, zero pad, left justify
//   rsp     | rsp_valid/rsp_ready  | one ascii character, last flag
//
// one transaction on req is loaded first, then each digit passes through the
// shared divide unit (multiply, then subtract), 1 to 10 digits, then one character
// per cycle goes out while rsp is taken.
// req_ready is high only while the sequencer is idle; the last character may still
// wait in the output register while the next transaction is accepted.
// reset is synchronous, active high, and clears the sequencer and rsp_valid.
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter #(
   parameter int MAX_FIELD_WIDTH = itoa_pkg::MAX_FIELD_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_value,
   input  wire logic [5:0]  req_field_width,
   input  wire logic        req_zero_pad,
   input  wire logic        req_left_justify,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_out_char,
   output logic             rsp_last_char
);

   localparam logic [5:0] MaxW = 6'(MAX_FIELD_WIDTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_SUB  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] mag_ff, mag_in;
   logic [3:0]  nd_ff, nd_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  width_ff;
   logic        neg_ff, left_ff, zpad_ff, upper_ff, hex_ff;
   logic [3:0]  digits_ff [itoa_pkg::DIGIT_DEPTH];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_char_ff;
   logic        rsp_last_ff;

   logic        req_fire;
   logic        neg_w;
   logic [31:0] quot;
   logic [3:0]  rem;
   logic [5:0]  total;
   logic [5:0]  pad;
   logic [5:0]  n_chars;
   logic        last_w;
   logic        load;
   logic [7:0]  char_w;
   itoa_pkg::fmt_type    fmt;
   itoa_pkg::digits_type digits_w;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign neg_w     = (req_type == itoa_pkg::KIND_SDEC) && req_value[31];

   // shared divide unit
   itoa_digit_unit u_digit (
      .clock  (clock),
      .mul_en (state_ff == ST_MUL),
      .hex    (hex_ff),
      .mag    (mag_ff),
      .quot   (quot),
      .rem    (rem)
   );

   // field layout
   assign total   = {2'b0, nd_ff} + {5'b0, neg_ff};
   assign pad     = (width_ff > total) ? (width_ff - total) : 6'd0;
   assign n_chars = (width_ff > total) ? width_ff : total;
   assign last_w  = (pos_ff == n_chars - 6'd1);
   assign load    = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign fmt = '{neg: neg_ff, left: left_ff, zpad: zpad_ff, upper: upper_ff,
                  nd: nd_ff, pad: pad};

   always_comb begin
      for (int i = 0; i < itoa_pkg::DIGIT_DEPTH; i++) begin
         digits_w[i] = digits_ff[i];
      end
   end

   itoa_char_select u_sel (
      .pos      (pos_ff),
      .fmt      (fmt),
      .digits   (digits_w),
      .out_char (char_w)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      nd_in    = nd_ff;
      pos_in   = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mag_in   = neg_w ? (~req_value + 32'd1) : req_value;
               nd_in    = 4'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_SUB;
         end
         ST_SUB: begin
            mag_in = quot;
            nd_in  = nd_ff + 4'd1;
            if (quot == 32'd0 || nd_ff == itoa_pkg::DIGIT_LIMIT) begin
               pos_in   = 6'd0;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (load) begin
               pos_in = pos_ff + 6'd1;
               if (last_w) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      nd_ff  <= nd_in;
      pos_ff <= pos_in;
      if (req_fire) begin
         width_ff <= (req_field_width > MaxW) ? MaxW : req_field_width;
         neg_ff   <= neg_w;
         left_ff  <= req_left_justify;
         zpad_ff  <= req_zero_pad;
         upper_ff <= (req_type == itoa_pkg::KIND_UHEX);
         hex_ff   <= (req_type == itoa_pkg::KIND_LHEX) || (req_type == itoa_pkg::KIND_UHEX);
      end
      if (state_ff == ST_SUB) begin
         digits_ff[nd_ff] <= rem;
      end
      if (load) begin
         rsp_char_ff <= char_w;
         rsp_last_ff <= last_w;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   // checks
   `ITOA_ASSERT_NOW(a_digit_count, clock, reset, state_ff == ST_SUB, nd_ff <= itoa_pkg::DIGIT_LIMIT)
   `ITOA_ASSERT_NEXT(a_fire_starts, clock, reset, req_fire, state_ff == ST_MUL)
   `ITOA_ASSERT_NOW(a_pos_range, clock, reset, state_ff == ST_EMIT, pos_ff < n_chars)
   `ITOA_ASSERT_NEXT(a_last_done, clock, reset, load && last_w, state_ff == ST_IDLE && rsp_last_char)

endmodule

`default_nettype wire

// ===== test/tb_integer_to_ascii_formatter.sv =====
// self-checking testbench for integer_to_ascii_formatter: printf style integer text
// depends on itoa_pkg and the rtl top level; a scoreboard class predicts each character
`default_nettype none

// one character of formatted text as seen on the rsp channel
typedef struct {
   logic [7:0] glyph;
   logic       last;
} text_char_type;

// one formatting request as driven on the req channel
typedef struct {
   logic [1:0]  kind;
   logic [31:0] value;
   logic [5:0]  width;
   logic        zpad;
   logic        left;
} fmt_request_type;

// predicts the text of each request and checks characters in order
class char_scoreboard;
   text_char_type expected_chars[$];
   int            mismatches;

   function new();
      mismatches = 0;
   endfunction

   // one failure, one line
   task report_mismatch(input string what);
      $display("itoa mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // format the accepted request and queue its characters
   function void note_request(input fmt_request_type r);
      string         lower_set;
      string         upper_set;
      logic [7:0]    rev[11];
      logic [7:0]    line[$];
      logic [31:0]   mag;
      bit            neg;
      int unsigned   radix;
      int            nd;
      int            total;
      int            pad;
      int            w;
      text_char_type c;
      lower_set = "0123456789abcdef";
      upper_set = "0123456789ABCDEF";
      // saturate to the widest field
      w = int'(r.width);
      if (w > itoa_pkg::MAX_FIELD_WIDTH_DEF) begin
         w = itoa_pkg::MAX_FIELD_WIDTH_DEF;
      end
      // sign and magnitude, most negative value wraps to itself
      neg = (r.kind == itoa_pkg::KIND_SDEC) && r.value[31];
      mag = neg ? (~r.value + 32'd1) : r.value;
      radix = (r.kind == itoa_pkg::KIND_LHEX || r.kind == itoa_pkg::KIND_UHEX) ? 16 : 10;
      // digits, least significant first
      nd = 0;
      do begin
         rev[nd] = (r.kind == itoa_pkg::KIND_UHEX) ? upper_set[mag % radix]
                                                   : lower_set[mag % radix];
         mag = mag / radix;
         nd++;
      end while (mag != 0 && nd < 11);
      total = nd + (neg ? 1 : 0);
      pad = (w > total) ? (w - total) : 0;
      // assemble the field: left justify wins over zero padding
      if (!r.left && !r.zpad) begin
         repeat (pad) line.push_back(itoa_pkg::CH_SPACE);
      end
      if (neg) begin
         line.push_back(itoa_pkg::CH_MINUS);
      end
      if (!r.left && r.zpad) begin
         repeat (pad) line.push_back(itoa_pkg::CH_ZERO);
      end
      for (int i = nd - 1; i >= 0; i--) begin
         line.push_back(rev[i]);
      end
      if (r.left) begin
         repeat (pad) line.push_back(itoa_pkg::CH_SPACE);
      end
      foreach (line[i]) begin
         c.glyph = line[i];
         c.last  = (i == line.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   // compare one accepted character against the oldest prediction
   task check_char(input logic [7:0] glyph, input logic last);
      text_char_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch($sformatf("unexpected char 0x%02h last %0b", glyph, last));
         return;
      end
      want = expected_chars.pop_front();
      if (glyph !== want.glyph) begin
         report_mismatch($sformatf("char 0x%02h, want 0x%02h", glyph, want.glyph));
      end
      if (last !== want.last) begin
         report_mismatch($sformatf("last flag %0b, want %0b", last, want.last));
      end
   endtask
endclass

module tb_integer_to_ascii_formatter;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [31:0] req_value;
   logic [5:0]  req_field_width;
   logic        req_zero_pad;
   logic        req_left_justify;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_char;

   char_scoreboard  sb;
   bit              no_idle;
   fmt_request_type rand_req;

   integer_to_ascii_formatter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_value        (req_value),
      .req_field_width  (req_field_width),
      .req_zero_pad     (req_zero_pad),
      .req_left_justify (req_left_justify),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // drive one request; entered and left at a falling edge
   task send_request(input logic [1:0] kind, input logic [31:0] value,
                     input logic [5:0] width, input logic zpad, input logic left);
      int              gap;
      fmt_request_type r;
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_value        <= value;
      req_field_width  <= width;
      req_zero_pad     <= zpad;
      req_left_justify <= left;
      do @(posedge clock); while (!req_ready);
      r.kind  = kind;
      r.value = value;
      r.width = width;
      r.zpad  = zpad;
      r.left  = left;
      sb.note_request(r);
      @(negedge clock);
   endtask

   // hold off the sender until every predicted character has come out
   task wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_chars.size() != 0) @(negedge clock);
   endtask

   // random request with bias toward boundaries and short fields
   function automatic fmt_request_type random_request();
      fmt_request_type r;
      int              pick;
      int              k;
      r.kind = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0, 1: r.value = $urandom;
         2: r.value = $urandom_range(0, 20);
         3: r.value = 32'd0 - $urandom_range(1, 100);
         4: begin
            k = $urandom_range(0, 31);
            r.value = (32'd1 << k) - $urandom_range(0, 1);
         end
         default: begin
            case ($urandom_range(0, 2))
               0: r.value = 32'h8000_0000;
               1: r.value = 32'h7FFF_FFFF;
               default: r.value = 32'hFFFF_FFFF;
            endcase
         end
      endcase
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         r.width = 6'($urandom_range(0, 12));
      end else if (pick < 19) begin
         r.width = 6'($urandom_range(0, 24));
      end else begin
         r.width = 6'($urandom_range(25, 63));
      end
      r.zpad = 1'($urandom_range(0, 1));
      r.left = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // check every accepted character
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_char(rsp_out_char, rsp_last_char);
      end
   end

   // receiver: random stall before each character, none during bursts
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 12);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      sb               = new();
      no_idle          = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_type         = itoa_pkg::KIND_SDEC;
      req_value        = 32'd0;
      req_field_width  = 6'd0;
      req_zero_pad     = 1'b0;
      req_left_justify = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes, every kind, every padding mode
      send_request(itoa_pkg::KIND_SDEC, 32'd0,          6'd0,  1'b0, 1'b0);
      send_request(itoa_pkg::KIND_SDEC, 32'h8000_0000, 6'd0,  1'b0, 1'b0);
      send_request(itoa_pkg::KIND_SDEC, 32'h7FFF_FFFF, 6'd0,  1'b0, 1'b0);
      send_request(itoa_pkg::KIND_SDEC, 32'hFFFF_FFFF, 6'd5,  1'b0, 1'b0);
      send_request(itoa_pkg::KIND_SDEC, -32'sd42,      6'd8,  1'b1, 1'b0);
      send_request(itoa_pkg::KIND_SDEC, -32'sd42,      6'd8,  1'b0, 1'b1);
      send_request(itoa_pkg::KIND_SDEC, -32'sd42,      6'd8,  1'b1, 1'b1);
      send_request(itoa_pkg::KIND_SDEC, 32'd5,         6'd1,  1'b1, 1'b0);
      send_request(itoa_pkg::KIND_SDEC, 32'h8000_0000, 6'd63, 1'b1, 1'b0);
      send_request(itoa_pkg::KIND_SDEC, 32'h8000_0000, 6'd63, 1'b0, 1'b1);
      send_request(itoa_pkg::KIND_UDEC, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b0);
      send_request(itoa_pkg::KIND_UDEC, 32'd123,       6'd2,  1'b1, 1'b0);
      send_request(itoa_pkg::KIND_UDEC, 32'd0,         6'd63, 1'b1, 1'b0);
      send_request(itoa_pkg::KIND_UDEC, 32'h8000_0000, 6'd11, 1'b0, 1'b0);
      send_request(itoa_pkg::KIND_LHEX, 32'hDEAD_BEEF, 6'd0,  1'b0, 1'b0);
      send_request(itoa_pkg::KIND_LHEX, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b1);
      send_request(itoa_pkg::KIND_LHEX, 32'h8000_0000, 6'd9,  1'b1, 1'b0);
      send_request(itoa_pkg::KIND_LHEX, 32'd0,         6'd0,  1'b1, 1'b1);
      send_request(itoa_pkg::KIND_UHEX, 32'hDEAD_BEEF, 6'd12, 1'b1, 1'b0);
      send_request(itoa_pkg::KIND_UHEX, 32'd0,         6'd1,  1'b0, 1'b0);
      send_request(itoa_pkg::KIND_UHEX, 32'h00AB_CDEF, 6'd63, 1'b0, 1'b0);
      send_request(itoa_pkg::KIND_UHEX, 32'h0000_000A, 6'd3,  1'b0, 1'b1);
      wait_drained();

      // random part with a burst window and a full drain midway
      for (int n = 0; n < 288; n++) begin
         no_idle = (n >= 120 && n < 170);
         if (n == 220) begin
            wait_drained();
         end
         rand_req = random_request();
         send_request(rand_req.kind, rand_req.value, rand_req.width,
                      rand_req.zpad, rand_req.left);
      end

      // let everything drain, then a few more cycles for stray output
      no_idle = 1'b0;
      wait_drained();
      repeat (40) @(negedge clock);
      if (sb.mismatches == 0) begin
         $display("[integer_to_ascii_formatter] OK");
      end else begin
         $display("[integer_to_ascii_formatter] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_500_000;
      $display("[integer_to_ascii_formatter] ERROR");
      $finish;
   end
endmodule

`default_nettype wire
